FILE: rtl/core/pms_tmr_pkg.sv
package pms_tmr_pkg;

    localparam int KIND_W   = 2;
    localparam int CHAN_W   = 4;
    localparam int OP_W     = 4;
    localparam int VALUE_W  = 32;
    localparam int EL_W     = 12;
    localparam int STATUS_W = 2;
    localparam int FIRES_W  = 13;
    localparam int WAIT_W   = 10;
    localparam int SUM_W    = VALUE_W + 1;
    localparam int FIRE_SLOTS = 4;
    localparam int STEP_W   = 4;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
    localparam logic [OP_W-1:0] OP_SET_PERIOD = 4'd1;
    localparam logic [OP_W-1:0] OP_START_STOP = 4'd2;

    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_CH = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_OP = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV_LOAD,
        ST_DIV_STEP,
        ST_SCAN,
        ST_DONE
    } tmr_state_t;

endpackage

FILE: rtl/core/four_channel_periodic_ms_timer_top.sv
// Periodic millisecond timer bank with NUM_TIMERS channels.
// Input channel (s_*): one beat is a register write, a register read or a
// time tick. Result channel (m_*): exactly one beat per input beat, carrying
// status, the read period, per-timer expiry counts and the next wait.
// A write or read passes from acceptance through EXEC, a SCAN of every timer
// and DONE before m_valid. A tick adds, after EXEC, a DIV_LOAD for each timer
// and, for each timer that is running with a nonzero period, DIV_STEP for its
// division; a single shared restoring divider produces one quotient bit per
// cycle, 13 bits per timer, and is followed by a one-timer-per-cycle minimum
// scan for next_wait.
// One beat is worked on at a time; s_ready is high only while idle, so the
// next beat is taken in the cycle after the result is written.
// The result sits in an output register, so a new beat is accepted while the
// previous result still waits for m_ready; a stalled receiver only holds the
// block at the point where the next result would be written.
// Reset (aresetn low, synchronous): all periods, counters and running flags
// clear, all timers stopped, no result pending.
module four_channel_periodic_ms_timer_top
    import pms_tmr_pkg::*;
#(
    parameter int NUM_TIMERS  = 4,
    parameter int MAX_WAIT_MS = 1000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [KIND_W-1:0]     s_kind,
    input  logic [CHAN_W-1:0]     s_channel,
    input  logic [OP_W-1:0]       s_op,
    input  logic [VALUE_W-1:0]    s_value,
    input  logic [EL_W-1:0]       s_elapsed_ms,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [VALUE_W-1:0]    m_read_period,
    output logic [FIRES_W-1:0]    m_fires_one,
    output logic [FIRES_W-1:0]    m_fires_two,
    output logic [FIRES_W-1:0]    m_fires_three,
    output logic [FIRES_W-1:0]    m_fires_four,
    output logic [WAIT_W-1:0]     m_next_wait
);

    localparam int TIDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int WREG_W   = $clog2(MAX_WAIT_MS + 1);
    localparam int LAST_STEP = FIRES_W - 1;

    tmr_state_t state_reg, state_next;
    logic [TIDX_W-1:0]   idx_reg, idx_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [EL_W-1:0]     el_reg, el_next;
    logic                chok_reg, chok_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [VALUE_W-1:0]  r_reg, r_next;
    logic [FIRES_W-1:0]  sh_reg, sh_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VALUE_W-1:0]  rdp_reg, rdp_next;
    logic [FIRES_W-1:0]  fires_reg [FIRE_SLOTS];
    logic [FIRES_W-1:0]  fires_next [FIRE_SLOTS];
    logic [WREG_W-1:0]   wait_reg, wait_next;

    logic [VALUE_W-1:0]  period_reg [NUM_TIMERS];
    logic [VALUE_W-1:0]  count_reg [NUM_TIMERS];
    logic                active_reg [NUM_TIMERS];

    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg;
    logic [VALUE_W-1:0]  m_rdp_reg;
    logic [FIRES_W-1:0]  m_fires_reg [FIRE_SLOTS];
    logic [WAIT_W-1:0]   m_wait_reg;
    logic                out_load;

    // single write port into the timer state, addressed by idx_reg
    logic                per_we, cnt_we, act_we, act_wdata;
    logic [VALUE_W-1:0]  per_wdata, cnt_wdata;

    logic [VALUE_W-1:0]  cur_per, cur_cnt;
    logic                cur_act, live, last_idx;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    trial, diff;
    logic                ge;
    logic [VALUE_W-1:0]  rem;
    logic [WREG_W-1:0]   wait_clamped;

    assign cur_per  = period_reg[idx_reg];
    assign cur_cnt  = count_reg[idx_reg];
    assign cur_act  = active_reg[idx_reg];
    assign live     = cur_act && (cur_per != '0);
    assign last_idx = (idx_reg == TIDX_W'(NUM_TIMERS - 1));
    assign sum      = {1'b0, cur_cnt} + SUM_W'(el_reg);

    // one quotient bit per cycle: shift in the next dividend bit, try subtract
    assign trial = {r_reg, sh_reg[FIRES_W-1]};
    assign diff  = trial - {1'b0, cur_per};
    assign ge    = (trial >= {1'b0, cur_per});

    assign rem          = (cur_cnt < cur_per) ? (cur_per - cur_cnt) : '0;
    assign wait_clamped = (wait_reg == '0) ? WREG_W'(1) : wait_reg;

    always_comb begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        kind_next   = kind_reg;
        op_next     = op_reg;
        value_next  = value_reg;
        el_next     = el_reg;
        chok_next   = chok_reg;
        step_next   = step_reg;
        r_next      = r_reg;
        sh_next     = sh_reg;
        status_next = status_reg;
        rdp_next    = rdp_reg;
        wait_next   = wait_reg;
        for (int j = 0; j < FIRE_SLOTS; j++) begin
            fires_next[j] = fires_reg[j];
        end
        per_we    = 1'b0;
        per_wdata = value_reg;
        cnt_we    = 1'b0;
        cnt_wdata = '0;
        act_we    = 1'b0;
        act_wdata = 1'b0;
        s_ready   = 1'b0;
        out_load  = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next   = s_kind;
                    op_next     = s_op;
                    value_next  = s_value;
                    el_next     = (s_elapsed_ms == '0) ? EL_W'(1) : s_elapsed_ms;
                    chok_next   = (s_channel != '0) &&
                                  (s_channel <= CHAN_W'(NUM_TIMERS));
                    idx_next    = TIDX_W'(s_channel - CHAN_W'(1));
                    status_next = STAT_OK;
                    rdp_next    = '0;
                    wait_next   = WREG_W'(MAX_WAIT_MS);
                    for (int j = 0; j < FIRE_SLOTS; j++) begin
                        fires_next[j] = '0;
                    end
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_SCAN;
                idx_next   = '0;
                unique case (kind_reg)
                    KIND_WRITE: begin
                        if (!chok_reg) begin
                            status_next = STAT_BAD_CH;
                        end else begin
                            unique case (op_reg)
                                OP_NOP: begin
                                end
                                OP_SET_PERIOD: begin
                                    per_we = 1'b1;
                                    cnt_we = 1'b1;
                                end
                                OP_START_STOP: begin
                                    act_we = 1'b1;
                                    if (value_reg != '0) begin
                                        act_wdata = 1'b1;
                                        cnt_we    = 1'b1;
                                    end
                                end
                                default: begin
                                    status_next = STAT_BAD_OP;
                                end
                            endcase
                        end
                    end
                    KIND_READ: begin
                        if (!chok_reg) begin
                            status_next = STAT_BAD_CH;
                        end else begin
                            rdp_next = cur_per;
                        end
                    end
                    KIND_TICK: begin
                        state_next = ST_DIV_LOAD;
                    end
                    default: begin
                        status_next = STAT_BAD_OP;
                    end
                endcase
            end
            ST_DIV_LOAD: begin
                if (live) begin
                    // count < period keeps the quotient within 13 bits
                    r_next     = VALUE_W'(sum[SUM_W-1:FIRES_W]);
                    sh_next    = sum[FIRES_W-1:0];
                    step_next  = '0;
                    state_next = ST_DIV_STEP;
                end else if (last_idx) begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end else begin
                    idx_next = idx_reg + TIDX_W'(1);
                end
            end
            ST_DIV_STEP: begin
                r_next    = ge ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
                sh_next   = {sh_reg[FIRES_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(LAST_STEP)) begin
                    cnt_we    = 1'b1;
                    cnt_wdata = r_next;
                    for (int j = 0; j < FIRE_SLOTS; j++) begin
                        if (int'(idx_reg) == j) begin
                            fires_next[j] = sh_next;
                        end
                    end
                    if (last_idx) begin
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end else begin
                        idx_next   = idx_reg + TIDX_W'(1);
                        state_next = ST_DIV_LOAD;
                    end
                end
            end
            ST_SCAN: begin
                if (live && (rem < VALUE_W'(wait_reg))) begin
                    wait_next = WREG_W'(rem);
                end
                if (last_idx) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + TIDX_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                period_reg[i] <= '0;
                count_reg[i]  <= '0;
                active_reg[i] <= 1'b0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (per_we) begin
                period_reg[idx_reg] <= per_wdata;
            end
            if (cnt_we) begin
                count_reg[idx_reg] <= cnt_wdata;
            end
            if (act_we) begin
                active_reg[idx_reg] <= act_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        kind_reg   <= kind_next;
        op_reg     <= op_next;
        value_reg  <= value_next;
        el_reg     <= el_next;
        chok_reg   <= chok_next;
        step_reg   <= step_next;
        r_reg      <= r_next;
        sh_reg     <= sh_next;
        status_reg <= status_next;
        rdp_reg    <= rdp_next;
        wait_reg   <= wait_next;
        for (int j = 0; j < FIRE_SLOTS; j++) begin
            fires_reg[j] <= fires_next[j];
        end
        if (out_load) begin
            m_status_reg <= status_reg;
            m_rdp_reg    <= rdp_reg;
            m_wait_reg   <= WAIT_W'(wait_clamped);
            for (int j = 0; j < FIRE_SLOTS; j++) begin
                m_fires_reg[j] <= fires_reg[j];
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_read_period = m_rdp_reg;
    assign m_fires_one   = m_fires_reg[0];
    assign m_fires_two   = m_fires_reg[1];
    assign m_fires_three = m_fires_reg[2];
    assign m_fires_four  = m_fires_reg[3];
    assign m_next_wait   = m_wait_reg;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import pms_tmr_pkg::*;

    localparam int NUM_TIMERS  = 4;
    localparam int MAX_WAIT_MS = 1000;
    localparam int RANDOM_BEATS = 450;
    localparam int HOLD_CYCLES  = 400;

    // codes the block has no name for
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam logic [OP_W-1:0]   OP_SPARE   = 4'd3;
    localparam logic [OP_W-1:0]   OP_TOP     = 4'd15;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAN_W-1:0]  channel;
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [EL_W-1:0]    elapsed_ms;
    } tmr_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]                  status;
        logic [VALUE_W-1:0]                   read_period;
        logic [FIRE_SLOTS-1:0][FIRES_W-1:0]   fires;
        logic [WAIT_W-1:0]                    next_wait;
    } tmr_result_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [KIND_W-1:0]   s_kind = '0;
    logic [CHAN_W-1:0]   s_channel = '0;
    logic [OP_W-1:0]     s_op = '0;
    logic [VALUE_W-1:0]  s_value = '0;
    logic [EL_W-1:0]     s_elapsed_ms = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [VALUE_W-1:0]  m_read_period;
    logic [FIRES_W-1:0]  m_fires_one;
    logic [FIRES_W-1:0]  m_fires_two;
    logic [FIRES_W-1:0]  m_fires_three;
    logic [FIRES_W-1:0]  m_fires_four;
    logic [WAIT_W-1:0]   m_next_wait;

    // predicted timer bank
    logic [VALUE_W-1:0] tmr_period  [NUM_TIMERS];
    logic [VALUE_W-1:0] tmr_count   [NUM_TIMERS];
    logic               tmr_running [NUM_TIMERS];

    tmr_beat_t   beats_to_send [$];
    tmr_result_t results_due   [$];

    int mismatches = 0;
    int beats_in = 0;
    int beats_out = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_ticks = 0;
    int n_rejected = 0;
    int total_fires = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always #2 aclk = ~aclk;

    four_channel_periodic_ms_timer_top #(
        .NUM_TIMERS  (NUM_TIMERS),
        .MAX_WAIT_MS (MAX_WAIT_MS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_channel     (s_channel),
        .s_op          (s_op),
        .s_value       (s_value),
        .s_elapsed_ms  (s_elapsed_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_period (m_read_period),
        .m_fires_one   (m_fires_one),
        .m_fires_two   (m_fires_two),
        .m_fires_three (m_fires_three),
        .m_fires_four  (m_fires_four),
        .m_next_wait   (m_next_wait)
    );

    function automatic tmr_result_t timer_bank_step(tmr_beat_t b);
        tmr_result_t        r;
        logic [SUM_W-1:0]   sum;
        logic [EL_W-1:0]    el;
        logic [VALUE_W-1:0] rem;
        logic [VALUE_W-1:0] least;
        bit                 chan_ok;
        int                 t;
        r = '0;
        chan_ok = (b.channel >= 1) && (b.channel <= NUM_TIMERS);
        t = int'(b.channel) - 1;
        case (b.kind)
            KIND_WRITE: begin
                if (!chan_ok) begin
                    r.status = STAT_BAD_CH;
                end else begin
                    case (b.op)
                        OP_NOP: ;
                        OP_SET_PERIOD: begin
                            tmr_period[t] = b.value;
                            tmr_count[t] = '0;
                        end
                        OP_START_STOP: begin
                            if (b.value != 0) begin
                                tmr_running[t] = 1'b1;
                                tmr_count[t] = '0;
                            end else begin
                                tmr_running[t] = 1'b0;
                            end
                        end
                        default: r.status = STAT_BAD_OP;
                    endcase
                end
            end
            KIND_READ: begin
                if (!chan_ok)
                    r.status = STAT_BAD_CH;
                else
                    r.read_period = tmr_period[t];
            end
            KIND_TICK: begin
                el = (b.elapsed_ms == 0) ? EL_W'(1) : b.elapsed_ms;
                for (int i = 0; i < NUM_TIMERS; i++) begin
                    if (tmr_running[i] && tmr_period[i] != 0) begin
                        sum = {1'b0, tmr_count[i]} + SUM_W'(el);
                        r.fires[i] = FIRES_W'(sum / {1'b0, tmr_period[i]});
                        tmr_count[i] = VALUE_W'(sum % {1'b0, tmr_period[i]});
                    end
                end
            end
            default: r.status = STAT_BAD_OP;
        endcase
        least = VALUE_W'(MAX_WAIT_MS);
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (tmr_running[i] && tmr_period[i] != 0) begin
                rem = (tmr_count[i] < tmr_period[i]) ? tmr_period[i] - tmr_count[i] : '0;
                if (rem < least)
                    least = rem;
            end
        end
        if (least == 0)
            least = VALUE_W'(1);
        r.next_wait = WAIT_W'(least);
        return r;
    endfunction

    task automatic queue_beat(logic [KIND_W-1:0] kind, logic [CHAN_W-1:0] channel,
                              logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                              logic [EL_W-1:0] elapsed_ms);
        beats_to_send.push_back(tmr_beat_t'{kind, channel, op, value, elapsed_ms});
    endtask

    function automatic logic [CHAN_W-1:0] draw_channel();
        if ($urandom_range(0, 99) < 92)
            return CHAN_W'($urandom_range(1, NUM_TIMERS));
        return CHAN_W'($urandom);
    endfunction

    // mostly well-formed traffic on live channels, small periods so ticks expire
    function automatic tmr_beat_t draw_beat();
        tmr_beat_t b;
        int        pick;
        int        vpick;
        b.kind = KIND_TICK;
        b.channel = draw_channel();
        b.op = OP_NOP;
        b.value = $urandom;
        b.elapsed_ms = ($urandom_range(0, 9) == 0) ? EL_W'($urandom)
                                                    : EL_W'($urandom_range(0, 150));
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            b.kind = KIND_W'($urandom);
            b.channel = CHAN_W'($urandom);
            b.op = OP_W'($urandom);
        end else if (pick < 30) begin
            b.kind = KIND_WRITE;
            b.op = OP_SET_PERIOD;
            vpick = $urandom_range(0, 99);
            if (vpick < 60)
                b.value = $urandom_range(1, 50);
            else if (vpick < 85)
                b.value = $urandom_range(1, 2000);
            else if (vpick < 93)
                b.value = '0;
        end else if (pick < 42) begin
            b.kind = KIND_WRITE;
            b.op = OP_START_STOP;
            if ($urandom_range(0, 3) == 0)
                b.value = '0;
            else if (b.value == 0)
                b.value = 1;
        end else if (pick < 50) begin
            b.kind = KIND_READ;
        end else if (pick < 53) begin
            b.kind = KIND_WRITE;
        end
        return b;
    endfunction

    task automatic log_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("result %0d: %s got %0h want %0h", beats_out, what, got, want);
    endtask

    // driver: one beat at a time from the pending queue
    always @(posedge aclk) begin : drv
        tmr_beat_t   nxt;
        tmr_result_t pred;
        bit          steady;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pred = timer_bank_step(tmr_beat_t'{s_kind, s_channel, s_op, s_value,
                                                   s_elapsed_ms});
                results_due.push_back(pred);
                beats_in++;
                if (pred.status != STAT_OK)
                    n_rejected++;
                else if (s_kind == KIND_WRITE)
                    n_writes++;
                else if (s_kind == KIND_READ)
                    n_reads++;
                else
                    n_ticks++;
            end
            if (!s_valid || s_ready) begin
                steady = (beats_in >= 250) && (beats_in < 330);
                if (beats_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 22)) begin
                    nxt = beats_to_send.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= nxt.kind;
                    s_channel <= nxt.channel;
                    s_op <= nxt.op;
                    s_value <= nxt.value;
                    s_elapsed_ms <= nxt.elapsed_ms;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result beat and paces m_ready
    always @(posedge aclk) begin : mon
        tmr_result_t want;
        bit          steady;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_out++;
                total_fires += int'(m_fires_one) + int'(m_fires_two) +
                               int'(m_fires_three) + int'(m_fires_four);
                if (results_due.size() == 0) begin
                    log_mismatch("beat with nothing due", {30'd0, m_status}, '0);
                end else begin
                    want = results_due.pop_front();
                    if (m_status != want.status)
                        log_mismatch("status", 32'(m_status), 32'(want.status));
                    if (m_read_period != want.read_period)
                        log_mismatch("read_period", m_read_period, want.read_period);
                    if (m_fires_one != want.fires[0])
                        log_mismatch("fires_one", 32'(m_fires_one), 32'(want.fires[0]));
                    if (m_fires_two != want.fires[1])
                        log_mismatch("fires_two", 32'(m_fires_two), 32'(want.fires[1]));
                    if (m_fires_three != want.fires[2])
                        log_mismatch("fires_three", 32'(m_fires_three), 32'(want.fires[2]));
                    if (m_fires_four != want.fires[3])
                        log_mismatch("fires_four", 32'(m_fires_four), 32'(want.fires[3]));
                    if (m_next_wait != want.next_wait)
                        log_mismatch("next_wait", 32'(m_next_wait), 32'(want.next_wait));
                end
            end
            // one long hold-off so the output register fills and s_ready drops
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && beats_out >= 120) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                steady = (beats_out >= 250) && (beats_out < 330);
                m_ready <= steady || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    initial begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            tmr_period[i] = '0;
            tmr_count[i] = '0;
            tmr_running[i] = 1'b0;
        end

        queue_beat(KIND_READ, 4'd1, OP_NOP, '0, '0);
        queue_beat(KIND_WRITE, 4'd0, OP_SET_PERIOD, 32'd5, '0);
        queue_beat(KIND_WRITE, 4'd5, OP_SET_PERIOD, 32'd5, '0);
        queue_beat(KIND_READ, 4'd15, OP_NOP, '0, '0);
        queue_beat(KIND_WRITE, 4'd1, OP_SPARE, 32'd5, '0);
        queue_beat(KIND_WRITE, 4'd4, OP_TOP, '1, '1);
        queue_beat(KIND_SPARE, 4'd2, OP_SET_PERIOD, 32'd9, 12'd3);
        queue_beat(KIND_WRITE, 4'd1, OP_NOP, '1, '0);
        queue_beat(KIND_WRITE, 4'd1, OP_SET_PERIOD, '1, '0);
        queue_beat(KIND_READ, 4'd1, OP_NOP, '0, '0);
        queue_beat(KIND_WRITE, 4'd2, OP_SET_PERIOD, 32'd1, '0);
        queue_beat(KIND_WRITE, 4'd2, OP_START_STOP, '1, '0);
        // running with a zero period never advances
        queue_beat(KIND_WRITE, 4'd3, OP_START_STOP, 32'd1, '0);
        queue_beat(KIND_TICK, 4'd0, OP_NOP, '0, 12'd0);
        queue_beat(KIND_TICK, 4'd0, OP_NOP, '0, '1);
        queue_beat(KIND_WRITE, 4'd1, OP_START_STOP, 32'd1, '0);
        queue_beat(KIND_TICK, 4'd0, OP_NOP, '0, '1);
        queue_beat(KIND_WRITE, 4'd2, OP_START_STOP, '0, '0);
        queue_beat(KIND_WRITE, 4'd4, OP_SET_PERIOD, 32'd7, '0);
        queue_beat(KIND_WRITE, 4'd4, OP_START_STOP, 32'h8000_0000, '0);
        queue_beat(KIND_TICK, 4'd0, OP_NOP, '0, 12'd10);
        queue_beat(KIND_WRITE, 4'd1, OP_SET_PERIOD, '0, '0);
        queue_beat(KIND_TICK, 4'd0, OP_NOP, '0, '1);
        // stopped timer keeps its count across a tick
        queue_beat(KIND_WRITE, 4'd4, OP_START_STOP, '0, '0);
        queue_beat(KIND_TICK, 4'd0, OP_NOP, '0, 12'd5);
        for (int i = 0; i < RANDOM_BEATS; i++)
            beats_to_send.push_back(draw_beat());

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (beats_to_send.size() != 0 || s_valid)
            @(posedge aclk);
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("%0d beats in, %0d out: %0d writes, %0d reads, %0d ticks, %0d rejected",
                 beats_in, beats_out, n_writes, n_reads, n_ticks, n_rejected);
        $display("%0d timer expiries reported, one receiver hold-off of %0d cycles",
                 total_fires, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results still due", results_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
